>>> rtl/cds_pkg.sv
// ---------------------------------------------------------------------------
// cds_pkg: shared constants and types for the clock divider search
// Search ranges, field widths, memory clock constants and the candidate
// record passed from the sequencer to the best-pair tracker.
// ---------------------------------------------------------------------------
package cds_pkg;

  // Field widths
  localparam int unsigned TARGET_W = 18;
  localparam int unsigned NUM_W    = 7;
  localparam int unsigned DEN_W    = 6;
  localparam int unsigned CODE_W   = 6;

  // Search ranges (upper bounds exclusive)
  localparam int unsigned NUM_LO = 16;
  localparam int unsigned NUM_HI = 127;
  localparam int unsigned DEN_LO = 20;
  localparam int unsigned DEN_HI = 63;

  // Distinct even divisors 20, 22, .. 62
  localparam int unsigned NUM_DIVS  = (DEN_HI - DEN_LO + 1) / 2;
  localparam int unsigned DIV_IDX_W = $clog2(NUM_DIVS);

  // Reference oscillator factor (default)
  localparam int unsigned OSC_FACTOR_KHZ = 28636;

  // Memory clock
  localparam int unsigned MCLK_BASE_KHZ = 14318;
  localparam int unsigned MCLK_PROD_W   = 20;
  localparam int unsigned MCLK_W        = MCLK_PROD_W - 3;
  localparam int unsigned MCLK_WINDOW   = 200;
  localparam int unsigned MCLK_SLACK    = 10;
  localparam logic [CODE_W-1:0] MCLK_CODE_RESET = CODE_W'(28);

  // Beat widths
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  // One candidate pair offered to the tracker
  typedef struct packed {
    logic             valid;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } cand_t;

endpackage

>>> rtl/cds_divstep.sv
// ---------------------------------------------------------------------------
// cds_divstep: incremental quotient of n * OSC / D
// Keeps quotient and remainder of n * OSC / D for the current even divisor D
// and on step_i steps n by one with a single add, compare and subtract per cycle.
// ---------------------------------------------------------------------------
module cds_divstep #(
  parameter int unsigned OscFactorKhz = cds_pkg::OSC_FACTOR_KHZ,
  parameter int unsigned ClkW         = 18
) (
  input  logic                           clk_i,
  input  logic                           clear_i,
  input  logic                           step_i,
  input  logic [cds_pkg::DIV_IDX_W-1:0]  div_idx_i,
  output logic [ClkW-1:0]                quot_o
);
  import cds_pkg::*;

  logic [ClkW-1:0]  q_tab [NUM_DIVS];
  logic [DEN_W-1:0] r_tab [NUM_DIVS];
  logic [ClkW-1:0]  quot_q, quot_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W:0]   rem_sum, den_full;
  logic             carry;

  // Per-divisor increments: OSC / D and OSC % D
  for (genvar g = 0; g < NUM_DIVS; g++) begin : g_tab
    localparam int unsigned Den = DEN_LO + 2 * g;
    localparam int unsigned Quo = OscFactorKhz / Den;
    localparam int unsigned Rem = OscFactorKhz % Den;
    assign q_tab[g] = ClkW'(Quo);
    assign r_tab[g] = DEN_W'(Rem);
  end

  // Remainder add with one conditional subtract
  assign den_full = (DEN_W+1)'(DEN_LO) + (DEN_W+1)'({div_idx_i, 1'b0});
  assign rem_sum  = {1'b0, rem_q} + {1'b0, r_tab[div_idx_i]};
  assign carry    = (rem_sum >= den_full);

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    if (clear_i) begin
      quot_d = '0;
      rem_d  = '0;
    end else if (step_i) begin
      quot_d = quot_q + q_tab[div_idx_i] + ClkW'(carry);
      rem_d  = carry ? DEN_W'(rem_sum - den_full) : DEN_W'(rem_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
  end

  assign quot_o = quot_q;

endmodule

>>> rtl/cds_best.sv
// ---------------------------------------------------------------------------
// cds_best: best-pair tracker
// Compares one candidate clock a cycle against the target and keeps the
// closest pair; ties go to the lower numerator, then the lower denominator.
// ---------------------------------------------------------------------------
module cds_best #(
  parameter int unsigned ClkW  = 18,
  parameter int unsigned DiffW = (ClkW > cds_pkg::TARGET_W) ? ClkW : cds_pkg::TARGET_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [cds_pkg::TARGET_W-1:0]  target_i,
  input  cds_pkg::cand_t                cand_i,
  input  logic [ClkW-1:0]               cand_clk_i,
  output logic [DiffW-1:0]              best_o,
  output logic [cds_pkg::NUM_W-1:0]     num_o,
  output logic [cds_pkg::DEN_W-1:0]     den_o,
  output logic                          found_o
);
  import cds_pkg::*;

  logic [DiffW-1:0] best_q, best_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic             hit_q, hit_d;
  logic [DiffW-1:0] c_ext, t_ext, diff;
  logic             earlier, better;

  // Absolute distance to the target
  assign c_ext = DiffW'(cand_clk_i);
  assign t_ext = DiffW'(target_i);
  assign diff  = (c_ext > t_ext) ? (c_ext - t_ext) : (t_ext - c_ext);

  // Strictly closer, or equally close and lower in numerator, then denominator order
  assign earlier = ({cand_i.num, cand_i.den} < {num_q, den_q});
  assign better  = cand_i.valid &&
                   ((diff < best_q) || (hit_q && (diff == best_q) && earlier));

  always_comb begin
    best_d = best_q;
    num_d  = num_q;
    den_d  = den_q;
    hit_d  = hit_q;
    if (start_i) begin
      best_d = t_ext;
      num_d  = '0;
      den_d  = '0;
      hit_d  = 1'b0;
    end else if (better) begin
      best_d = diff;
      num_d  = cand_i.num;
      den_d  = cand_i.den;
      hit_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    num_q  <= num_d;
    den_q  <= den_d;
  end

  assign best_o  = best_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign found_o = hit_q;

endmodule

>>> rtl/clock_divider_search_core.sv
// ---------------------------------------------------------------------------
// clock_divider_search_core: pixel clock divider search
// Scans numerator/denominator pairs for the closest pixel clock to a target
// and checks whether the configured memory clock is close enough to serve.
//
//   channel   dir  beat fields (lsb first)
//   s_axis    in   tdata: target_khz[17:0]
//   m_axis    out  tdata: numerator[6:0], denominator[12:7], use_mclk[13],
//                         found[14]
//   cfg       in   cfg_wdata_i: mclk_code[5:0], written when cfg_we_i high
//
// Each item goes through accept, 22 divisor passes and finish.
// Each pass runs n = 0..126 through one shared quotient step unit; n below 16
// offers no candidate, otherwise the even then the odd denominator get one compare each.
// s_axis_tready_o is high only while idle; a result waits in the output
// register and the next target is taken meanwhile.
// Reset clears control state and sets mclk_code to 28.
// ---------------------------------------------------------------------------
module clock_divider_search_core #(
  parameter int unsigned OscFactorKhz = cds_pkg::OSC_FACTOR_KHZ
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // target_khz[17:0]
  input  logic [cds_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // numerator[6:0], denominator[12:7], use_mclk[13], found[14]
  output logic [cds_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_we_i,
  input  logic [cds_pkg::CODE_W-1:0]          cfg_wdata_i
);
  import cds_pkg::*;

  localparam int unsigned ClkMax = (NUM_HI - 1) * OscFactorKhz / DEN_LO;
  localparam int unsigned ClkW   = $clog2(ClkMax + 1);
  localparam int unsigned DiffW  = (ClkW > TARGET_W) ? ClkW : TARGET_W;
  localparam int unsigned MdW    = (MCLK_W > TARGET_W) ? MCLK_W : TARGET_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_RUN    = 3'b010,
    S_FINISH = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [DIV_IDX_W-1:0]   di_q, di_d;
  logic [NUM_W-1:0]       n_q, n_d;
  logic                   ph_q, ph_d;
  logic [TARGET_W-1:0]    target_q, target_d;
  logic [CODE_W-1:0]      mclk_code_q;
  logic                   m_valid_q, m_valid_d;
  logic [NUM_W-1:0]       out_num_q;
  logic [DEN_W-1:0]       out_den_q;
  logic                   out_use_q, out_found_q;

  logic                   start, acc_clear, acc_step, load_out;
  logic                   in_beat;
  cand_t                  cand;
  logic [ClkW-1:0]        quot, cand_clk;
  logic [DEN_W-1:0]       den_even, den_odd;
  logic                   n_in_range, last_n, last_div;

  logic [DiffW-1:0]       best;
  logic [NUM_W-1:0]       best_num;
  logic [DEN_W-1:0]       best_den;
  logic                   found;

  logic [MCLK_PROD_W-1:0] mclk_prod;
  logic [MdW-1:0]         mclk_ext, tgt_ext, mdist;
  logic                   use_mclk;

  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mclk_code_q <= MCLK_CODE_RESET;
    end else if (cfg_we_i) begin
      mclk_code_q <= cfg_wdata_i;
    end
  end

  // Scan position decode
  assign den_even   = DEN_W'(DEN_LO) + DEN_W'({di_q, 1'b0});
  assign den_odd    = den_even + DEN_W'(1);
  assign n_in_range = (n_q >= NUM_W'(NUM_LO));
  assign last_n     = (n_q == NUM_W'(NUM_HI - 1));
  assign last_div   = (di_q == DIV_IDX_W'(NUM_DIVS - 1));
  assign cand_clk   = ph_q ? (quot >> 1) : quot;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    di_d       = di_q;
    n_d        = n_q;
    ph_d       = ph_q;
    target_d   = target_q;
    start      = 1'b0;
    acc_clear  = 1'b0;
    acc_step   = 1'b0;
    load_out   = 1'b0;
    cand.valid = 1'b0;
    cand.num   = n_q;
    cand.den   = ph_q ? den_odd : den_even;
    unique case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          target_d  = s_axis_tdata_i[TARGET_W-1:0];
          start     = 1'b1;
          acc_clear = 1'b1;
          di_d      = '0;
          n_d       = '0;
          ph_d      = 1'b0;
          state_d   = S_RUN;
        end
      end
      S_RUN: begin
        // even denominator needs n >= d; d = 63 is out of range
        cand.valid = n_in_range && (ph_q ? !last_div : (n_q >= NUM_W'(den_even)));
        ph_d       = n_in_range && !ph_q;
        if (!n_in_range || ph_q) begin
          if (last_n) begin
            if (last_div) begin
              state_d = S_FINISH;
            end else begin
              di_d      = di_q + DIV_IDX_W'(1);
              n_d       = '0;
              acc_clear = 1'b1;
            end
          end else begin
            n_d      = n_q + NUM_W'(1);
            acc_step = 1'b1;
          end
        end
      end
      S_FINISH: begin
        if (!m_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      di_q    <= '0;
      n_q     <= '0;
      ph_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      di_q    <= di_d;
      n_q     <= n_d;
      ph_q    <= ph_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q <= target_d;
  end

  // Shared quotient step unit
  cds_divstep #(
    .OscFactorKhz (OscFactorKhz),
    .ClkW         (ClkW)
  ) u_divstep (
    .clk_i     (clk_i),
    .clear_i   (acc_clear),
    .step_i    (acc_step),
    .div_idx_i (di_q),
    .quot_o    (quot)
  );

  // Closest-pair tracker
  cds_best #(
    .ClkW  (ClkW),
    .DiffW (DiffW)
  ) u_best (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .target_i   (target_d),
    .cand_i     (cand),
    .cand_clk_i (cand_clk),
    .best_o     (best),
    .num_o      (best_num),
    .den_o      (best_den),
    .found_o    (found)
  );

  // Memory clock check
  assign mclk_prod = MCLK_PROD_W'(MCLK_BASE_KHZ) * MCLK_PROD_W'(mclk_code_q);
  assign mclk_ext  = MdW'(mclk_prod[MCLK_PROD_W-1:3]);
  assign tgt_ext   = MdW'(target_q);
  assign mdist     = (mclk_ext > tgt_ext) ? (mclk_ext - tgt_ext) : (tgt_ext - mclk_ext);
  assign use_mclk  = ((DiffW+1)'(mdist) <= ((DiffW+1)'(best) + (DiffW+1)'(MCLK_SLACK))) ||
                     (mdist <= MdW'(MCLK_WINDOW));

  // Output register
  always_comb begin
    m_valid_d = m_valid_q;
    if (load_out) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_num_q   <= best_num;
      out_den_q   <= best_den;
      out_use_q   <= use_mclk;
      out_found_q <= found;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_found_q, out_use_q, out_den_q, out_num_q};

  // Checks
  a_run_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (di_q <= DIV_IDX_W'(NUM_DIVS - 1)))
    else $error("divisor index beyond last divisor");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == S_RUN) && (n_q == '0) && (di_q == '0))
    else $error("accepted beat did not start a scan");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !out_found_q) |-> (out_num_q == '0) && (out_den_q == '0))
    else $error("pair reported without a hit");

  a_found_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_found_q) |->
      (out_num_q >= NUM_W'(NUM_LO)) && (out_den_q >= DEN_W'(DEN_LO)) &&
      (out_den_q[0] || (out_num_q >= NUM_W'(out_den_q))))
    else $error("reported pair outside the legal set");

  a_load_only_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (state_q == S_FINISH))
    else $error("result loaded outside finish");

endmodule

>>> tb/sv/clock_divider_search_core_tb.sv
// ---------------------------------------------------------------------------
// clock_divider_search_core_tb: self-checking bench for the divider search
// Streams target clocks into the core, predicts the chosen numerator and
// denominator, the memory clock flag and the found flag for each beat, and
// compares every output beat in order. A directed table covers the extremes
// and the memory clock window edges, then random targets run over several
// memory clock codes with random idling on both sides and one long output
// hold-off that backs the core up.
// ---------------------------------------------------------------------------
module clock_divider_search_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import cds_pkg::*;

  // Search constants of the divider scheme
  localparam int unsigned OSC_KHZ   = 28636;
  localparam int unsigned MCLK_KHZ  = 14318;
  localparam int unsigned N_FIRST   = 16;
  localparam int unsigned N_END     = 127;
  localparam int unsigned D_FIRST   = 20;
  localparam int unsigned D_END     = 63;
  localparam int unsigned WINDOW    = 200;
  localparam int unsigned SLACK     = 10;
  localparam int unsigned TGT_MAX   = 262143;

  // Run control
  localparam int unsigned CODE_RST     = 28;
  localparam int unsigned RAND_PHASES  = 6;
  localparam int unsigned RAND_ITEMS   = 16;
  localparam int unsigned HOLD_PHASE   = 2;
  localparam int unsigned HOLD_CYCLES  = 12000;
  localparam int unsigned TAIL_CYCLES  = 6000;
  localparam int unsigned CYCLE_LIMIT  = 4000000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned N_ROWS       = 24;

  // One result beat
  typedef struct packed {
    logic [6:0] num;
    logic [5:0] den;
    logic       use_mclk;
    logic       found;
  } pll_pair_t;

  // One row of the directed table
  typedef struct {
    logic [CODE_W-1:0] code;
    logic [17:0]       target;
    bit                typed;
    pll_pair_t         pair;
  } target_row_t;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic                   cfg_we_i        = 1'b0;
  logic [CODE_W-1:0]      cfg_wdata_i     = '0;

  pll_pair_t         pending_pairs[$];
  logic [CODE_W-1:0] mclk_code_now = CODE_W'(CODE_RST);
  int unsigned       error_count   = 0;
  int unsigned       cycle_count   = 0;
  int unsigned       src_calm      = 0;
  int unsigned       snk_calm      = 0;
  bit                hold_pending  = 1'b0;
  target_row_t       rows[N_ROWS];

  clock_divider_search_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    // target_khz[17:0]
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    // numerator[6:0], denominator[12:7], use_mclk[13], found[14]
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // Clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Memory clock for a given code
  function automatic int unsigned mclk_of(input logic [CODE_W-1:0] code);
    return (MCLK_KHZ * int'(code)) / 8;
  endfunction

  // Closest divider pair for a target, plus the memory clock verdict
  function automatic pll_pair_t search_dividers(input logic [17:0] target,
                                                input logic [CODE_W-1:0] code);
    pll_pair_t   res;
    int unsigned best;
    int unsigned fclk;
    int unsigned diff;
    int unsigned mclk;
    int unsigned md;
    res  = '0;
    best = 32'(target);
    for (int unsigned n = N_FIRST; n < N_END; n++) begin
      for (int unsigned d = D_FIRST; d < D_END; d++) begin
        // even denominators above the numerator are unstable
        if (n < d && d[0] == 1'b0) continue;
        fclk = ((n * OSC_KHZ) / (d & 32'h3E)) >> (d & 1);
        diff = (fclk > target) ? fclk - target : target - fclk;
        if (diff < best) begin
          best      = diff;
          res.num   = n[6:0];
          res.den   = d[5:0];
          res.found = 1'b1;
        end
      end
    end
    mclk = mclk_of(code);
    md   = (mclk > target) ? mclk - target : target - mclk;
    res.use_mclk = (md <= best + SLACK) || (md <= WINDOW);
    return res;
  endfunction

  // Idle draw: a random gap, with the odd calm stretch of back-to-back beats
  function automatic int unsigned draw_gap(inout int unsigned calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(4, 12);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Offer one target beat; returns in the step it is taken, tvalid still high
  task automatic push_target(input logic [17:0] target, input bit typed,
                             input pll_pair_t typed_pair);
    int unsigned gap;
    gap = draw_gap(src_calm);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= {{(IN_TDATA_W-18){1'b0}}, target};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (typed) pending_pairs.push_back(typed_pair);
    else pending_pairs.push_back(search_dividers(target, mclk_code_now));
  endtask

  // Stop offering and wait until every result beat has come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
  endtask

  // Register write while the core is idle
  task automatic write_code(input logic [CODE_W-1:0] code);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    mclk_code_now = code;
  endtask

  // Random target: wide, realistic, near the memory clock, or very low
  function automatic logic [17:0] draw_target();
    int unsigned pick;
    int          near;
    pick = $urandom_range(0, 9);
    if (pick <= 3) return 18'($urandom());
    if (pick <= 6) return 18'($urandom_range(3000, 200000));
    if (pick <= 8) begin
      near = int'(mclk_of(mclk_code_now)) + int'($urandom_range(0, 600)) - 300;
      return (near < 0) ? 18'd0 : 18'(near);
    end
    return 18'($urandom_range(0, 4000));
  endfunction

  // Directed table: typed rows are read straight off the scheme
  initial begin
    rows[0]  = '{6'd28, 18'd0,         1'b1, '{7'd0,   6'd0,  1'b0, 1'b0}};
    rows[1]  = '{6'd28, 18'(TGT_MAX),  1'b1, '{7'd126, 6'd20, 1'b0, 1'b1}};
    rows[2]  = '{6'd28, 18'd1,         1'b1, '{7'd0,   6'd0,  1'b0, 1'b0}};
    rows[3]  = '{6'd28, 18'd50113,     1'b0, '0};
    rows[4]  = '{6'd28, 18'd50313,     1'b0, '0};
    rows[5]  = '{6'd28, 18'd50314,     1'b0, '0};
    rows[6]  = '{6'd28, 18'd49912,     1'b0, '0};
    rows[7]  = '{6'd28, 18'd3694,      1'b0, '0};
    rows[8]  = '{6'd28, 18'd1846,      1'b0, '0};
    rows[9]  = '{6'd28, 18'd180406,    1'b1, '{7'd126, 6'd20, 1'b0, 1'b1}};
    rows[10] = '{6'd28, 18'd25175,     1'b0, '0};
    rows[11] = '{6'd28, 18'h2AAAA,     1'b0, '0};
    rows[12] = '{6'd28, 18'h15555,     1'b0, '0};
    rows[13] = '{6'd0,  18'd0,         1'b1, '{7'd0,   6'd0,  1'b1, 1'b0}};
    rows[14] = '{6'd0,  18'd200,       1'b0, '0};
    rows[15] = '{6'd0,  18'd201,       1'b0, '0};
    rows[16] = '{6'd0,  18'd131071,    1'b0, '0};
    rows[17] = '{6'd63, 18'(TGT_MAX),  1'b1, '{7'd126, 6'd20, 1'b0, 1'b1}};
    rows[18] = '{6'd63, 18'd112754,    1'b0, '0};
    rows[19] = '{6'd63, 18'd112954,    1'b0, '0};
    rows[20] = '{6'd63, 18'd0,         1'b1, '{7'd0,   6'd0,  1'b0, 1'b0}};
    rows[21] = '{6'd63, 18'd90203,     1'b0, '0};
    rows[22] = '{6'd1,  18'd1789,      1'b0, '0};
    rows[23] = '{6'd1,  18'd1600,      1'b0, '0};
  end

  // Output side: random stalls, one long hold-off, in-order compare
  initial begin : result_sink
    int unsigned stall_left;
    pll_pair_t   exp_pair;
    pll_pair_t   got_pair;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_pair = {m_axis_tdata_o[6:0], m_axis_tdata_o[12:7],
                    m_axis_tdata_o[13], m_axis_tdata_o[14]};
        if (pending_pairs.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result beat: %h", m_axis_tdata_o);
        end else begin
          exp_pair = pending_pairs.pop_front();
          if (got_pair.num !== exp_pair.num || got_pair.den !== exp_pair.den ||
              got_pair.use_mclk !== exp_pair.use_mclk ||
              got_pair.found !== exp_pair.found || m_axis_tdata_o[15] !== 1'b0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("mismatch: exp n=%0d d=%0d mclk=%0b found=%0b",
                       exp_pair.num, exp_pair.den, exp_pair.use_mclk, exp_pair.found);
              $display("          got n=%0d d=%0d mclk=%0b found=%0b pad=%0b",
                       got_pair.num, got_pair.den, got_pair.use_mclk, got_pair.found,
                       m_axis_tdata_o[15]);
            end
          end
        end
        stall_left = draw_gap(snk_calm);
      end else if (!m_axis_tready_i && stall_left > 0) begin
        stall_left--;
      end
      // long hold-off so the core fills and blocks its input
      if (hold_pending) begin
        stall_left   = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      m_axis_tready_i <= (stall_left == 0);
    end
  end

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("clock_divider_search_core_tb: errors");
    $finish;
  end

  // Stimulus
  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, code changes only with the core drained
    for (int unsigned i = 0; i < N_ROWS; i++) begin
      if (rows[i].code != mclk_code_now) begin
        drain_results();
        write_code(rows[i].code);
      end
      push_target(rows[i].target, rows[i].typed, rows[i].pair);
    end

    // random phases, one fresh code each
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      drain_results();
      write_code(CODE_W'($urandom_range(0, 63)));
      if (ph == HOLD_PHASE) hold_pending = 1'b1;
      for (int unsigned k = 0; k < RAND_ITEMS; k++)
        push_target(draw_target(), 1'b0, '0);
    end

    // wind down and watch for stray beats
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_pairs.size() == 0)
      $display("clock_divider_search_core_tb: clean");
    else
      $display("clock_divider_search_core_tb: errors");
    $finish;
  end

endmodule

>>> clock_divider_search_core.f
rtl/cds_pkg.sv
rtl/cds_divstep.sv
rtl/cds_best.sv
rtl/clock_divider_search_core.sv
tb/sv/clock_divider_search_core_tb.sv
